// ===== hdl/srf_pkg.sv =====
// srf_pkg: shared constants for the substring removal filter.
// No dependencies; used by srf_front, srf_back and the top module (srf_fifo does not use it).
`default_nettype none
package srf_pkg;

    // default longest pattern (window depth)
    localparam int MAX_PATTERN_DEF = 8;

    // command queue depth between front and back
    localparam int CMD_FIFO_DEPTH = 4;

    // register widths
    localparam int PAT_BYTES_W = 64;
    localparam int PAT_LEN_W   = 4;
    localparam int CHAR_W      = 8;

    // APB port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;

    // register index, taken from paddr[3] (8-byte stride)
    localparam logic REG_PATTERN_BYTES  = 1'b0;
    localparam logic REG_PATTERN_LENGTH = 1'b1;

endpackage
`default_nettype wire

// ===== hdl/srf_fifo.sv =====
// srf_fifo: small ring-buffer queue holding commands from front to back.
// Depends on nothing but its parameters.
`default_nettype none
module srf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DEPTH-1:0][WIDTH-1:0] r_mem;
    logic [PW-1:0]               r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]               r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]               r_count, n_count;
    logic                        do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/srf_front.sv =====
// srf_front: character window, pattern compare and command generation.
// Depends on srf_pkg.
`default_nettype none
module srf_front #(
    parameter int MAX_PATTERN = srf_pkg::MAX_PATTERN_DEF,
    localparam int CW = $clog2(MAX_PATTERN + 1)
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic [srf_pkg::PAT_BYTES_W-1:0]          i_pattern_bytes,
    input  wire logic [srf_pkg::PAT_LEN_W-1:0]            i_pattern_length,
    input  wire logic                                     i_cfg_clear,
    input  wire logic                                     i_accept,
    input  wire logic [srf_pkg::CHAR_W-1:0]               i_text_char,
    input  wire logic                                     i_char_present,
    input  wire logic                                     i_text_end,
    output logic                                          o_cmd_push,
    output logic [MAX_PATTERN-1:0][srf_pkg::CHAR_W-1:0]   o_cmd_chars,
    output logic [CW-1:0]                                 o_cmd_n,
    output logic                                          o_cmd_end
);
    logic [MAX_PATTERN-1:0][srf_pkg::CHAR_W-1:0] r_win, n_win;
    logic [CW-1:0]                               r_count, n_count;
    logic [MAX_PATTERN-1:0][srf_pkg::CHAR_W-1:0] w_ins;
    logic [CW-1:0]                               cnt_ins;
    logic [CW-1:0]                               eff_len;
    logic                                        win_full;
    logic                                        mismatch;

    // clamp length to window depth
    assign eff_len = (i_pattern_length > srf_pkg::PAT_LEN_W'(MAX_PATTERN))
                     ? CW'(MAX_PATTERN) : i_pattern_length[CW-1:0];

    always_comb begin
        w_ins = r_win;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (i_char_present && r_count == CW'(i)) begin
                w_ins[i] = i_text_char;
            end
        end
        cnt_ins  = i_char_present ? r_count + 1'b1 : r_count;
        win_full = i_char_present && (eff_len != '0) && (cnt_ins == eff_len);

        mismatch = 1'b0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (CW'(i) < eff_len && w_ins[i] != i_pattern_bytes[8*i +: 8]) begin
                mismatch = 1'b1;
            end
        end

        o_cmd_chars = w_ins;
        o_cmd_end   = i_text_end;
        n_win       = w_ins;
        n_count     = cnt_ins;
        if (i_char_present && eff_len == '0) begin
            // empty pattern: pass through
            o_cmd_chars[0] = i_text_char;
            o_cmd_n        = CW'(1);
            n_count        = '0;
        end else if (win_full && !mismatch) begin
            // match: drop the window
            o_cmd_n = '0;
            n_count = '0;
        end else if (win_full) begin
            // emit oldest; on end, the whole window goes out in order
            o_cmd_n = i_text_end ? cnt_ins : CW'(1);
            for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                n_win[i] = w_ins[i+1];
            end
            n_count = cnt_ins - 1'b1;
        end else begin
            o_cmd_n = i_text_end ? cnt_ins : '0;
        end
        if (i_text_end) begin
            n_count = '0;
        end
        o_cmd_push = i_accept && (o_cmd_n != '0 || i_text_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_clear) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/srf_back.sv =====
// srf_back: expands queued commands into result beats in the output register, one per
// cycle while that register is empty or being popped. Depends on srf_pkg.
`default_nettype none
module srf_back #(
    parameter int MAX_PATTERN = srf_pkg::MAX_PATTERN_DEF,
    localparam int CW = $clog2(MAX_PATTERN + 1)
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_cmd_valid,
    input  wire logic [MAX_PATTERN-1:0][srf_pkg::CHAR_W-1:0] i_cmd_chars,
    input  wire logic [CW-1:0]                            i_cmd_n,
    input  wire logic                                     i_cmd_end,
    output logic                                          o_cmd_pop,
    input  wire logic                                     i_pop,
    output logic                                          o_empty,
    output logic [srf_pkg::CHAR_W-1:0]                    o_kept_char,
    output logic                                          o_kept_present,
    output logic                                          o_result_end
);
    logic                         r_out_valid;
    logic [srf_pkg::CHAR_W-1:0]   r_kept_char, n_kept_char;
    logic                         r_kept_present, n_kept_present;
    logic                         r_result_end, n_result_end;
    logic [CW-1:0]                r_idx, n_idx;
    logic                         advance;
    logic                         last_beat;
    logic [srf_pkg::CHAR_W-1:0]   sel_char;

    assign o_empty        = !r_out_valid;
    assign o_kept_char    = r_kept_char;
    assign o_kept_present = r_kept_present;
    assign o_result_end   = r_result_end;

    assign advance = i_cmd_valid && (!r_out_valid || i_pop);

    always_comb begin
        sel_char = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (r_idx == CW'(i)) begin
                sel_char = i_cmd_chars[i];
            end
        end
        last_beat = (i_cmd_n == '0) || (r_idx == i_cmd_n - 1'b1);
        if (i_cmd_n == '0) begin
            // bare end marker
            n_kept_char    = '0;
            n_kept_present = 1'b0;
            n_result_end   = 1'b1;
        end else begin
            n_kept_char    = sel_char;
            n_kept_present = 1'b1;
            n_result_end   = i_cmd_end && last_beat;
        end
        n_idx     = r_idx;
        o_cmd_pop = 1'b0;
        if (advance) begin
            if (last_beat) begin
                n_idx     = '0;
                o_cmd_pop = 1'b1;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_idx <= n_idx;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_kept_char    <= n_kept_char;
            r_kept_present <= n_kept_present;
            r_result_end   <= n_result_end;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/substring_removal_filter_top.sv =====
// substring_removal_filter_top: streaming removal of a configured pattern.
// With the back end idle, an accepted item's command is written to the command queue, then
//   the back end moves its first result beat into the output register. Throughput: one item
//   per cycle; an end item flushing n characters (n up to MAX_PATTERN) holds the back end for
//   its n beats while the 4-deep queue takes three more commands, then full stalls the input.
// Reset (i_rst_n, sync, active low): pattern registers zero, window and queues empty.
`default_nettype none
module substring_removal_filter_top #(
    parameter int MAX_PATTERN = srf_pkg::MAX_PATTERN_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // APB config port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [srf_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [srf_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [srf_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    // input queue side
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [srf_pkg::CHAR_W-1:0]      i_text_char,
    input  wire logic                            i_char_present,
    input  wire logic                            i_text_end,
    // result queue side
    output logic                                 empty,
    input  wire logic                            pop,
    output logic      [srf_pkg::CHAR_W-1:0]      o_kept_char,
    output logic                                 o_kept_present,
    output logic                                 o_result_end
);
    localparam int CW     = $clog2(MAX_PATTERN + 1);
    localparam int CMD_W  = MAX_PATTERN * srf_pkg::CHAR_W + CW + 1;

    // configuration registers
    logic [srf_pkg::PAT_BYTES_W-1:0] r_pattern_bytes;
    logic [srf_pkg::PAT_LEN_W-1:0]   r_pattern_length;
    logic                            cfg_wr;

    // front -> queue
    logic                                        accept;
    logic                                        cmd_push;
    logic [MAX_PATTERN-1:0][srf_pkg::CHAR_W-1:0] cmd_chars;
    logic [CW-1:0]                               cmd_n;
    logic                                        cmd_end;

    // queue -> back
    logic [CMD_W-1:0]                            q_data;
    logic                                        q_full, q_empty, q_pop;
    logic [MAX_PATTERN-1:0][srf_pkg::CHAR_W-1:0] hd_chars;
    logic [CW-1:0]                               hd_n;
    logic                                        hd_end;

    // ------------------------------------------------------------------
    // APB: always ready, register index is paddr[3] (8-byte stride).
    // Any register write also empties the window.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_bytes  <= '0;
            r_pattern_length <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3])
                srf_pkg::REG_PATTERN_BYTES:  r_pattern_bytes  <= pwdata;
                srf_pkg::REG_PATTERN_LENGTH:
                    r_pattern_length <= pwdata[srf_pkg::PAT_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3])
            srf_pkg::REG_PATTERN_BYTES:  prdata = r_pattern_bytes;
            srf_pkg::REG_PATTERN_LENGTH:
                prdata = srf_pkg::APB_DATA_W'(r_pattern_length);
            default: prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Front: every accepted beat updates the window; beats that yield
    // output (or end the text) post one command to the queue.
    // ------------------------------------------------------------------
    assign full   = q_full;
    assign accept = push && !q_full;

    srf_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pattern_bytes  (r_pattern_bytes),
        .i_pattern_length (r_pattern_length),
        .i_cfg_clear      (cfg_wr),
        .i_accept         (accept),
        .i_text_char      (i_text_char),
        .i_char_present   (i_char_present),
        .i_text_end       (i_text_end),
        .o_cmd_push       (cmd_push),
        .o_cmd_chars      (cmd_chars),
        .o_cmd_n          (cmd_n),
        .o_cmd_end        (cmd_end)
    );

    // command queue decouples front from the flush expander
    srf_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (srf_pkg::CMD_FIFO_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  ({cmd_end, cmd_n, cmd_chars}),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign {hd_end, hd_n, hd_chars} = q_data;

    // ------------------------------------------------------------------
    // Back: one result beat per cycle into the output register while it is empty or popped.
    // ------------------------------------------------------------------
    srf_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (!q_empty),
        .i_cmd_chars    (hd_chars),
        .i_cmd_n        (hd_n),
        .i_cmd_end      (hd_end),
        .o_cmd_pop      (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_kept_char    (o_kept_char),
        .o_kept_present (o_kept_present),
        .o_result_end   (o_result_end)
    );

endmodule
`default_nettype wire
